/* design/star_polling_central_scheduler_unit_macros.svh */
// Assertion macros for the polling scheduler checker
`ifndef STAR_POLLING_CENTRAL_SCHEDULER_UNIT_MACROS_SVH
`define STAR_POLLING_CENTRAL_SCHEDULER_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent on the same edge
`define SPCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
// Assert that an antecedent implies a consequent on the following edge
`define SPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`endif

/* design/spcs_pkg.sv */
package spcs_pkg;
	localparam int MaxNodesDefault = 64;
	localparam logic [31:0] PhaseLenReset = 32'd2500;
	localparam logic [31:0] TimeoutReset = 32'd30000;
	localparam logic [7:0] HdrLen = 8'd16;
	localparam logic [7:0] IdBase = 8'd10;
	localparam logic [7:0] MinRxLen = 8'd6;
	localparam logic [7:0] MaxUserLen = 8'd239;

	localparam logic [1:0] CmdLoop = 2'd0;
	localparam logic [1:0] CmdPayload = 2'd1;
	localparam logic [1:0] CmdQueue = 2'd2;
	localparam logic [1:0] CmdReserved = 2'd3;

	localparam logic CfgPhaseLen = 1'b0;
	localparam logic CfgTimeout = 1'b1;

	// table operation requested by the sequencer
	typedef struct packed {
		logic        wr_id;
		logic        wr_seen;
		logic        wr_pay;
		logic [5:0]  wr_addr;
		logic [31:0] id_d;
		logic [31:0] seen_d;
		logic [63:0] pay_d;
		logic [5:0]  rd_addr;
	} tbl_req_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] seen;
		logic [63:0] pay;
	} tbl_rsp_t;
endpackage

/* design/star_polling_central_scheduler_unit.sv */
// Polling scheduler: one result per item, by a sequencer over a node table with one write
// and one read port. Queue and reserved commands answer from the classify state; a payload set
// compares the table slots in turn; a loop item may run a poll reply compare or an enumeration
// search, then the timer step holds or advances the phase; a wrap to phase 0 adds an eviction
// pass shifting the table down over each stale node. Next item accepted at the result transfer.
// Reset (arst_n low): registers to defaults; then a payload clear pass over all MAX_NODES slots.
module star_polling_central_scheduler_unit #(
	parameter int MAX_NODES = spcs_pkg::MaxNodesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: command[1:0], rx_valid[2], rx_crc_ok[3], rx_length[11:4], rx_unit_id[43:12],
	// now_us[75:44], now_ms[107:76], target_node_id[139:108], down_payload[203:140],
	// user_length[211:204], zeros to 215
	input  logic [215:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: tx_valid[0], tx_packet_id[8:1], tx_length[16:9], tx_target_id[48:17],
	// tx_node_count[55:49], tx_word[119:56], rx_accepted[120], rx_node_index[126:121],
	// zero at 127
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import spcs_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b00000000001,
		ST_IDLE   = 11'b00000000010,
		ST_SRCH   = 11'b00000000100,
		ST_SCMP   = 11'b00000001000,
		ST_POLL   = 11'b00000010000,
		ST_PCMP   = 11'b00000100000,
		ST_TIMER  = 11'b00001000000,
		ST_EVRD   = 11'b00010000000,
		ST_EVCMP  = 11'b00100000000,
		ST_SHIFT  = 11'b01000000000,
		ST_HDR    = 11'b10000000000
	} st_t;

	localparam logic [6:0] MaxN = 7'(MAX_NODES);

	st_t st_q;
	logic [31:0] plen_q, tmo_q, pstart_q;
	logic [6:0] cnt_q, phase_q, i_q, j_q;
	logic [7:0] qlen_q;
	logic [211:0] in_q;
	logic out_v_q;
	logic [127:0] out_q;
	logic acc_q;
	logic [5:0] aidx_q;
	logic shift_rd_q;
	tbl_req_t req;
	tbl_rsp_t rsp;

	logic [1:0] cmd;
	logic rxv, rxok;
	logic [7:0] rxlen, ulen;
	logic [31:0] rxid, nus, nms, tgt;
	logic [63:0] pay;
	assign cmd = in_q[1:0];
	assign rxv = in_q[2];
	assign rxok = in_q[3];
	assign rxlen = in_q[11:4];
	assign rxid = in_q[43:12];
	assign nus = in_q[75:44];
	assign nms = in_q[107:76];
	assign tgt = in_q[139:108];
	assign pay = in_q[203:140];
	assign ulen = in_q[211:204];

	logic rx_good, hold, stale;
	logic [6:0] nphase;
	logic [31:0] key;
	assign rx_good = rxv && rxok && (rxlen >= MinRxLen);
	assign hold = ((nus - pstart_q) < plen_q) && (nus > pstart_q);
	assign nphase = (phase_q + 7'd1 > cnt_q) ? 7'd0 : phase_q + 7'd1;
	assign stale = (nms - rsp.seen) > tmo_q;
	assign key = (cmd == CmdPayload) ? tgt : rxid;

	// search and write decisions
	logic enum_rx, scmp_hit, scmp_end, add_now, pay_now, seen_now;
	assign enum_rx = (cmd == CmdLoop) && rx_good && (phase_q == 7'd0) && (rxid != 32'd0);
	assign scmp_hit = (rsp.id == key);
	assign scmp_end = (i_q + 7'd1) >= cnt_q;
	assign add_now = ((st_q == ST_SRCH) && enum_rx && (cnt_q == 7'd0)) ||
		((st_q == ST_SCMP) && (cmd == CmdLoop) && !scmp_hit && scmp_end && (cnt_q < MaxN));
	assign pay_now = (st_q == ST_SCMP) && (cmd == CmdPayload) && scmp_hit;
	assign seen_now = (st_q == ST_PCMP) && (rsp.id == rxid);

	// header fields
	logic [7:0] hdr_pid, hdr_len;
	logic [31:0] hdr_tgt;
	logic [63:0] hdr_word;
	assign hdr_pid = (phase_q == 7'd0) ? 8'd0 : IdBase + 8'(phase_q);
	assign hdr_len = HdrLen + qlen_q;
	assign hdr_tgt = (phase_q == 7'd0) ? 32'd0 : rsp.id;
	assign hdr_word = (phase_q == 7'd0) ? {plen_q, nms} : rsp.pay;

	assign s_axis_tready = (st_q == ST_IDLE) && (!out_v_q || m_axis_tready);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;
	assign cfg_ready = 1'b1;

	// table requests
	always_comb begin
		req = '0;
		req.id_d = rxid;
		req.seen_d = nms;
		req.pay_d = '0;
		req.wr_addr = i_q[5:0];
		req.rd_addr = i_q[5:0];
		case (st_q)
			ST_CLEAR: begin
				req.wr_pay = 1'b1;
			end
			ST_SRCH: begin
				if (add_now) begin
					req.wr_id = 1'b1;
					req.wr_seen = 1'b1;
					req.wr_addr = cnt_q[5:0];
				end
			end
			ST_SCMP: begin
				req.rd_addr = 6'(i_q + 7'd1);
				if (add_now) begin
					req.wr_id = 1'b1;
					req.wr_seen = 1'b1;
					req.wr_addr = cnt_q[5:0];
				end
				if (pay_now) begin
					req.wr_pay = 1'b1;
					req.pay_d = pay;
				end
			end
			ST_POLL: req.rd_addr = 6'(phase_q - 7'd1);
			ST_PCMP: begin
				if (seen_now) begin
					req.wr_seen = 1'b1;
					req.wr_addr = 6'(phase_q - 7'd1);
				end
			end
			ST_TIMER: req.rd_addr = 6'(nphase - 7'd1);
			ST_SHIFT: begin
				req.rd_addr = j_q[5:0];
				req.wr_addr = 6'(j_q - 7'd1);
				req.id_d = rsp.id;
				req.seen_d = rsp.seen;
				req.pay_d = rsp.pay;
				if (shift_rd_q) begin
					if (j_q < cnt_q) begin
						req.wr_id = 1'b1;
						req.wr_seen = 1'b1;
						req.wr_pay = 1'b1;
					end else begin
						req.wr_pay = 1'b1;
						req.pay_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	spcs_table #(.MAX_NODES(MAX_NODES)) u_tbl (.clk(clk), .req(req), .rsp(rsp));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= PhaseLenReset;
			tmo_q <= TimeoutReset;
		end else if (cfg_valid) begin
			if (cfg_index == CfgPhaseLen) plen_q <= cfg_data;
			else tmo_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			cnt_q <= '0;
			phase_q <= '0;
			pstart_q <= '0;
			qlen_q <= '0;
			i_q <= '0;
			j_q <= '0;
			in_q <= '0;
			out_q <= '0;
			out_v_q <= 1'b0;
			acc_q <= 1'b0;
			aidx_q <= '0;
			shift_rd_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					if (i_q == MaxN - 7'd1) begin
						i_q <= '0;
						st_q <= ST_IDLE;
					end else i_q <= i_q + 7'd1;
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						in_q <= s_axis_tdata[211:0];
						i_q <= '0;
						acc_q <= 1'b0;
						aidx_q <= '0;
						st_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					// classify the item
					if (cmd == CmdQueue) begin
						qlen_q <= (ulen > MaxUserLen) ? MaxUserLen : ulen;
						out_q <= '0;
						out_v_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (cmd == CmdPayload) begin
						if (cnt_q == 7'd0) begin
							out_q <= '0;
							out_v_q <= 1'b1;
							st_q <= ST_IDLE;
						end else st_q <= ST_SCMP;
					end else if (cmd == CmdLoop) begin
						if (enum_rx) begin
							if (add_now) begin
								cnt_q <= cnt_q + 7'd1;
								st_q <= ST_TIMER;
							end else st_q <= ST_SCMP;
						end else if (rx_good && phase_q != 7'd0 && phase_q <= cnt_q) begin
							st_q <= ST_POLL;
						end else st_q <= ST_TIMER;
					end else begin
						out_q <= '0;
						out_v_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				ST_SCMP: begin
					// compare entry i, read data registered from last cycle
					if (scmp_hit || scmp_end) begin
						if (cmd == CmdPayload) begin
							out_q <= '0;
							out_v_q <= 1'b1;
							st_q <= ST_IDLE;
						end else begin
							if (add_now) cnt_q <= cnt_q + 7'd1;
							st_q <= ST_TIMER;
						end
					end else i_q <= i_q + 7'd1;
				end
				ST_POLL: st_q <= ST_PCMP;
				ST_PCMP: begin
					if (seen_now) begin
						acc_q <= 1'b1;
						aidx_q <= 6'(phase_q - 7'd1);
					end
					st_q <= ST_TIMER;
				end
				ST_TIMER: begin
					if (hold) begin
						out_q <= {1'b0, aidx_q, acc_q, 120'd0};
						out_v_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						pstart_q <= nus;
						phase_q <= nphase;
						i_q <= '0;
						st_q <= (nphase == 7'd0) ? ST_EVRD : ST_HDR;
					end
				end
				ST_EVRD: begin
					if (i_q >= cnt_q) st_q <= ST_HDR;
					else st_q <= ST_EVCMP;
				end
				ST_EVCMP: begin
					if (stale) begin
						j_q <= i_q + 7'd1;
						shift_rd_q <= 1'b0;
						st_q <= ST_SHIFT;
					end else begin
						i_q <= i_q + 7'd1;
						st_q <= ST_EVRD;
					end
				end
				ST_SHIFT: begin
					// read entry j, then write it to j-1; clear the payload of the last slot
					if (!shift_rd_q) begin
						shift_rd_q <= 1'b1;
					end else if (j_q < cnt_q) begin
						j_q <= j_q + 7'd1;
						shift_rd_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - 7'd1;
						st_q <= ST_EVRD;
					end
				end
				ST_HDR: begin
					out_q <= {1'b0, aidx_q, acc_q, hdr_word, cnt_q, hdr_tgt, hdr_len, hdr_pid,
						1'b1};
					if (phase_q == 7'd0) qlen_q <= '0;
					out_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* design/spcs_table.sv */
module spcs_table #(
	parameter int MAX_NODES = spcs_pkg::MaxNodesDefault
) (
	input  logic              clk,
	input  spcs_pkg::tbl_req_t req,
	output spcs_pkg::tbl_rsp_t rsp
);
	import spcs_pkg::*;
	logic [31:0] id_mem [MAX_NODES];
	logic [31:0] seen_mem [MAX_NODES];
	logic [63:0] pay_mem [MAX_NODES];
	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	// write one entry, read one entry, registered data
	always_ff @(posedge clk) begin
		if (req.wr_id) id_mem[req.wr_addr[AW-1:0]] <= req.id_d;
		if (req.wr_seen) seen_mem[req.wr_addr[AW-1:0]] <= req.seen_d;
		if (req.wr_pay) pay_mem[req.wr_addr[AW-1:0]] <= req.pay_d;
		rsp.id <= id_mem[req.rd_addr[AW-1:0]];
		rsp.seen <= seen_mem[req.rd_addr[AW-1:0]];
		rsp.pay <= pay_mem[req.rd_addr[AW-1:0]];
	end
endmodule

/* design/spcs_checker.sv */
module spcs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
`include "star_polling_central_scheduler_unit_macros.svh"
	`SPCS_ASSERT_NEXT(a_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`SPCS_ASSERT_IMP(a_txlen, clk, arst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[16:9] >= 8'd16)
	`SPCS_ASSERT_IMP(a_idle, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[119:1] == '0)
	`SPCS_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind star_polling_central_scheduler_unit spcs_checker u_chk (.*);
